// ----- sv/plm_pkg.sv -----
`default_nettype none

package plm_pkg;

   localparam int POS_W    = 8;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int IO_W     = 32;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SWAP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INS,
      MODE_REM,
      MODE_SWP
   } cell_mode_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_mode_type     mode;
      logic [POS_W-1:0]  pos_a;
      logic [POS_W-1:0]  pos_b;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- sv/plm_cell.sv -----
`default_nettype none

module plm_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire plm_pkg::cell_ctrl_type ctrl,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic [DATA_WIDTH-1:0] word,
   input  wire logic [DATA_WIDTH-1:0] data_a,
   input  wire logic [DATA_WIDTH-1:0] data_b,
   output logic      [DATA_WIDTH-1:0] data_q,
   output logic      [DATA_WIDTH-1:0] tap_a,
   output logic      [DATA_WIDTH-1:0] tap_b
);
   import plm_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.mode)
         MODE_INS: begin
            if (IDX == ctrl.pos_a) begin
               data_in = word;
            end else if (IDX > ctrl.pos_a) begin
               data_in = left_data;
            end
         end
         MODE_REM: begin
            if (IDX >= ctrl.pos_a) begin
               data_in = right_data;
            end
         end
         MODE_SWP: begin
            if (IDX == ctrl.pos_a) begin
               data_in = data_b;
            end else if (IDX == ctrl.pos_b) begin
               data_in = data_a;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;
   assign tap_a  = (IDX == ctrl.pos_a) ? data_ff : '0;
   assign tap_b  = (IDX == ctrl.pos_b) ? data_ff : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_engine_top.sv -----
`default_nettype none
// A request passes through capture, gather and apply before its response beat.
// A new request is taken only once the previous one is applied, since the addressed
// words are gathered from the cell chain before the chain is updated in the apply cycle.
// A new request is taken while the previous response still waits.
// Reset (synchronous) empties the list and drops any pending response;
// cell contents are not cleared and are never read before being written.

module positional_list_engine_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [plm_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [plm_pkg::POS_W-1:0]     req_position,
   input  wire logic [plm_pkg::POS_W-1:0]     req_position_b,
   input  wire logic [plm_pkg::IO_W-1:0]      req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [plm_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [plm_pkg::IO_W-1:0]      rsp_read_value,
   output logic      [CNT_W-1:0]              rsp_count_now
);
   import plm_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_GATHER = 2'd1;
   localparam logic [1:0] S_APPLY  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [POS_W-1:0]      pa_ff, pb_ff;
   logic [IO_W-1:0]       value_ff;
   logic [DATA_WIDTH-1:0] data_a_ff, data_b_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, status_in;
   logic [IO_W-1:0]       rsp_read_value_ff, read_value_in;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  apply_go;
   logic [POS_W:0]        cnt_ext, pa_ext, pb_ext;
   logic                  is_full, is_empty, range_a, range_b;
   logic [POS_W-1:0]      ins_pos, rem_pos;
   cell_ctrl_type         ctrl;
   logic [63:0]           word_wide, rd_wide;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] gather_a, gather_b;

   logic [DATA_WIDTH-1:0] cell_q [DEPTH];
   logic [DATA_WIDTH-1:0] tap_a  [DEPTH];
   logic [DATA_WIDTH-1:0] tap_b  [DEPTH];

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign apply_go  = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);

   assign cnt_ext  = (POS_W + 1)'(count_ff);
   assign pa_ext   = {1'b0, pa_ff};
   assign pb_ext   = {1'b0, pb_ff};
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign range_a  = (pa_ext >= cnt_ext);
   assign range_b  = (pb_ext >= cnt_ext);
   // past the end: insert appends, remove takes the last word
   assign ins_pos  = (pa_ext > cnt_ext) ? cnt_ext[POS_W-1:0] : pa_ff;
   assign rem_pos  = range_a ? POS_W'(cnt_ext - (POS_W + 1)'(1)) : pa_ff;

   assign word_wide = 64'(value_ff);
   assign word      = word_wide[DATA_WIDTH-1:0];
   assign rd_wide   = 64'(data_a_ff);

   always_comb begin
      ctrl.mode  = MODE_HOLD;
      ctrl.pos_a = pa_ff;
      ctrl.pos_b = pb_ff;
      status_in  = ST_OK;
      count_in   = count_ff;
      read_value_in = '0;
      case (func_ff)
         FUNC_INSERT: begin
            ctrl.pos_a = ins_pos;
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               if (apply_go) ctrl.mode = MODE_INS;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            ctrl.pos_a = rem_pos;
            if (is_empty) begin
               status_in = ST_RANGE;
            end else begin
               if (apply_go) ctrl.mode = MODE_REM;
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_READ: begin
            if (range_a) begin
               status_in = ST_RANGE;
            end else begin
               read_value_in = rd_wide[IO_W-1:0];
            end
         end
         FUNC_SWAP: begin
            if (range_a || range_b) begin
               status_in = ST_RANGE;
            end else if (apply_go) begin
               ctrl.mode = MODE_SWP;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      plm_cell #(
         .INDEX      (k),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  ((k == 0) ? word : cell_q[(k == 0) ? 0 : k - 1]),
         .right_data ((k == DEPTH - 1) ? cell_q[k] : cell_q[(k == DEPTH - 1) ? k : k + 1]),
         .word       (word),
         .data_a     (data_a_ff),
         .data_b     (data_b_ff),
         .data_q     (cell_q[k]),
         .tap_a      (tap_a[k]),
         .tap_b      (tap_b[k])
      );
   end

   // at most one cell matches each position
   always_comb begin
      gather_a = '0;
      gather_b = '0;
      for (int k = 0; k < DEPTH; k++) begin
         gather_a = gather_a | tap_a[k];
         gather_b = gather_b | tap_b[k];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_GATHER;
         S_GATHER: state_in = S_APPLY;
         S_APPLY:  if (apply_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff  <= req_func;
         pa_ff    <= req_position;
         pb_ff    <= req_position_b;
         value_ff <= req_value;
      end
      if (state_ff == S_GATHER) begin
         data_a_ff <= gather_a;
         data_b_ff <= gather_b;
      end
      if (apply_go) begin
         rsp_status_ff     <= status_in;
         rsp_read_value_ff <= read_value_in;
         rsp_count_ff      <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count_now  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count exceeds depth");

   a_count_moves_on_apply: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(apply_go))
      else $error("count changed outside an apply cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      apply_go && (ctrl.mode == MODE_INS) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list by one");

   a_apply_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      apply_go |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("apply did not present a response");

   a_no_rsp_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) && rsp_valid_ff && !rsp_ready |=> state_ff == S_APPLY)
      else $error("apply overran a pending response");

endmodule

`default_nettype wire

// ----- test/tb_positional_list_engine_top.sv -----
`default_nettype none

module tb_positional_list_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   import plm_pkg::*;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_AFTER   = 200;
   localparam int HOLD_CYCLES  = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [POS_W-1:0]      req_position;
   logic [POS_W-1:0]      req_position_b;
   logic [IO_W-1:0]       req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [IO_W-1:0]       rsp_read_value;
   logic [CNT_W-1:0]      rsp_count_now;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IO_W-1:0]     read_value;
      logic [CNT_W-1:0]    count_now;
   } list_outcome_type;

   // Mirror of the list contents; predicts one outcome per accepted request.
   class list_tracker_type;
      logic [IO_W-1:0]  words [DEPTH];
      int unsigned      fill;
      list_outcome_type pending [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      full_hits;
      int unsigned      range_hits;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         full_hits = 0;
         range_hits = 0;
      endfunction

      function void apply_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos_a,
                                  logic [POS_W-1:0] pos_b, logic [IO_W-1:0] word);
         list_outcome_type o;
         int unsigned      a;
         int unsigned      b;
         int unsigned      k;
         logic [IO_W-1:0]  tmp;
         o.status     = ST_OK;
         o.read_value = '0;
         a = pos_a;
         b = pos_b;
         case (func)
            FUNC_INSERT: begin
               if (fill >= DEPTH) begin
                  o.status = ST_FULL;
               end else begin
                  if (a > fill) a = fill;
                  for (k = fill; k > a; k--) words[k] = words[k-1];
                  words[a] = word;
                  fill++;
               end
            end
            FUNC_REMOVE: begin
               if (fill == 0) begin
                  o.status = ST_RANGE;
               end else begin
                  if (a >= fill) a = fill - 1;
                  for (k = a; k + 1 < fill; k++) words[k] = words[k+1];
                  fill--;
               end
            end
            FUNC_READ: begin
               if (a >= fill) o.status = ST_RANGE;
               else o.read_value = words[a];
            end
            default: begin
               if (a >= fill || b >= fill) begin
                  o.status = ST_RANGE;
               end else if (a != b) begin
                  tmp = words[a];
                  words[a] = words[b];
                  words[b] = tmp;
               end
            end
         endcase
         o.count_now = fill[CNT_W-1:0];
         pending.push_back(o);
      endfunction

      function void match_response(logic [STATUS_W-1:0] status, logic [IO_W-1:0] read_value,
                                   logic [CNT_W-1:0] count_now);
         list_outcome_type exp;
         if (pending.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (exp.status == ST_FULL) full_hits++;
         if (exp.status == ST_RANGE) range_hits++;
         if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
         end
         if (read_value !== exp.read_value) begin
            $error("read_value: expected %h, got %h", exp.read_value, read_value);
            errors++;
         end
         if (count_now !== exp.count_now) begin
            $error("count_now: expected %0d, got %0d", exp.count_now, count_now);
            errors++;
         end
      endfunction
   endclass

   list_tracker_type tracker = new();
   bit          tx_calm = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned responses_seen = 0;

   positional_list_engine_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_position_b (req_position_b),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count_now  (rsp_count_now)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones; none at all when calm
   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // leans towards the head (push/pop/top), with some far out of range
   function automatic logic [POS_W-1:0] pick_position(int unsigned fill);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12) return POS_W'($urandom_range(0, 255));
      if (r < 35 || fill == 0) return '0;
      return POS_W'($urandom_range(0, fill));
   endfunction

   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos_a,
                               input logic [POS_W-1:0] pos_b, input logic [IO_W-1:0] word);
      int unsigned gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_position   <= pos_a;
      req_position_b <= pos_b;
      req_value      <= word;
      do @(posedge clock); while (!req_ready);
      tracker.apply_request(func, pos_a, pos_b, word);
      requests_sent++;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // response side: random stalls, calm stretches, and one long hold-off
   initial begin : response_sink
      int unsigned stall_left = 0;
      int unsigned hold_left = 0;
      int unsigned since_shuffle = 0;
      bit          rx_calm = 1'b0;
      bit          held_off = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.match_response(rsp_status, rsp_read_value, rsp_count_now);
            responses_seen++;
         end
         @(negedge clock);
         if (!held_off && responses_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         since_shuffle++;
         if (since_shuffle == 128) begin
            since_shuffle = 0;
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap(rx_calm);
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int unsigned idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned      directed;
      int unsigned      n;
      int unsigned      r;
      bit               growing;
      logic [FUNC_W-1:0] func;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_INSERT;
      req_position   = '0;
      req_position_b = '0;
      req_value      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: every operation that can fail on it
      send_request(FUNC_READ,   8'd0,   8'd0, $urandom);
      send_request(FUNC_REMOVE, 8'd0,   8'd0, $urandom);
      send_request(FUNC_SWAP,   8'd0,   8'd0, $urandom);
      // append far past the end, then push at the head
      send_request(FUNC_INSERT, 8'd255, 8'd0, 32'hffff_ffff);
      send_request(FUNC_INSERT, 8'd0,   8'd0, 32'h0000_0000);
      while (tracker.fill < DEPTH)
         send_request(FUNC_INSERT, pick_position(tracker.fill), 8'd0, $urandom);
      send_request(FUNC_INSERT, 8'd3,   8'd0, $urandom);
      send_request(FUNC_READ,   8'd0,   8'd0, $urandom);
      send_request(FUNC_READ,   8'd15,  8'd0, $urandom);
      send_request(FUNC_READ,   8'd16,  8'd0, $urandom);
      send_request(FUNC_SWAP,   8'd3,   8'd3, $urandom);
      send_request(FUNC_SWAP,   8'd0,   8'd15, $urandom);
      send_request(FUNC_SWAP,   8'd2,   8'd200, $urandom);
      send_request(FUNC_REMOVE, 8'd255, 8'd0, $urandom);
      send_request(FUNC_REMOVE, 8'd0,   8'd0, $urandom);
      send_request(FUNC_REMOVE, 8'd5,   8'd0, $urandom);
      directed = requests_sent;

      // random: alternate filling and draining so both full and empty recur
      growing = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) growing = ~growing;
         if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (growing)
            func = (r < 55) ? FUNC_INSERT : (r < 70) ? FUNC_REMOVE :
                   (r < 85) ? FUNC_READ : FUNC_SWAP;
         else
            func = (r < 15) ? FUNC_INSERT : (r < 55) ? FUNC_REMOVE :
                   (r < 80) ? FUNC_READ : FUNC_SWAP;
         send_request(func, pick_position(tracker.fill), pick_position(tracker.fill),
                      $urandom);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.pending.size() != 0) begin
         $error("%0d expected responses never arrived", tracker.pending.size());
         tracker.errors++;
      end

      $display("Sent %0d requests (%0d directed), checked %0d responses", requests_sent,
               directed, tracker.checked);
      $display("Outcomes seen: %0d full, %0d empty or out of range", tracker.full_hits,
               tracker.range_hits);
      if (tracker.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
